### rtl/vrt_pkg.sv
package vrt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CELL_BITS = 16;
   localparam int DIR_FRAC  = 14;
   localparam int LEN_W     = 16;
   localparam int MAG_W     = DIR_FRAC + 1;
   localparam int DIV_W     = (FRAC_BITS + DIR_FRAC + 1 > 30) ? FRAC_BITS + DIR_FRAC + 1 : 30;
   localparam int ITER_W    = $clog2(DIV_W + 1);

   localparam logic [FRAC_BITS:0] CELL_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [DIV_W-1:0]   INC_NUM  = DIV_W'(1) << (FRAC_BITS + DIR_FRAC);

   localparam logic OP_START = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_HIT   = 2'd1;
   localparam logic [1:0] KIND_MISS  = 2'd2;

   localparam logic [1:0] DIV_MAG = 2'd0;
   localparam logic [1:0] DIV_INC = 2'd1;
   localparam logic [1:0] DIV_NB  = 2'd2;

   typedef struct packed {
      logic               op;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [30:0]        max_dist;
      logic               cell_stops;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_z;
      logic [30:0]        distance;
      logic [1:0]         normal_axis;
      logic               normal_negative;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_sel;
      logic [1:0] axis;
      logic       sat_axis;
      logic       advance;
      logic       emit;
      logic [1:0] emit_kind;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic len_zero;
      logic mag_zero;
      logic past_limit;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

### rtl/vrt_dp.sv
module vrt_dp (
   input  logic             clock,
   input  logic             reset,
   input  vrt_pkg::req_type req_data,
   input  vrt_pkg::cmd_type cmd,
   input  logic             rsp_stall,
   output vrt_pkg::sts_type sts,
   output vrt_pkg::rsp_type rsp_data,
   output logic             rsp_valid
);
   import vrt_pkg::*;

   logic signed [CELL_BITS-1:0] cell_ff [3], cell_in [3];
   logic [31:0]          nb_ff [3], nb_in [3], inc_ff [3], inc_in [3];
   logic [16:0]          dabs_ff [3], dabs_in [3];
   logic [FRAC_BITS-1:0] frac_ff [3], frac_in [3];
   logic [2:0]           pos_ff, pos_in, dpos_ff, dpos_in;
   logic [31:0]          trav_ff, trav_in;
   logic [30:0]          limit_ff, limit_in;
   logic [1:0]           face_ff, face_in;
   logic [31:0]          srem_ff, srem_in, root_ff, root_in, bit_ff, bit_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [LEN_W-1:0]     rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [ITER_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, sqrt_ff, sqrt_in;
   logic [1:0]           sel_ff, sel_in, ax_ff, ax_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] dir [3];
   logic signed [31:0] org [3];
   logic signed [31:0] dw [3];
   logic [31:0]        sq_sum;
   logic [32:0]        s_sum;
   logic               s_ge;
   logic [16:0]        shl;
   logic [17:0]        diff;
   logic               q_bit;
   logic [DIV_W-1:0]   quo_next;
   logic [FRAC_BITS:0] num;
   logic [1:0]         adv;
   logic [32:0]        nb_sum;
   logic               neg;

   assign dir[0] = req_data.dir_x;
   assign dir[1] = req_data.dir_y;
   assign dir[2] = req_data.dir_z;
   assign org[0] = req_data.origin_x;
   assign org[1] = req_data.origin_y;
   assign org[2] = req_data.origin_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dw[a] = 32'(dir[a]);
      end
      sq_sum = 32'(dw[0] * dw[0]) + 32'(dw[1] * dw[1]) + 32'(dw[2] * dw[2]);
      s_sum  = {1'b0, root_ff} + {1'b0, bit_ff};
      s_ge   = {1'b0, srem_ff} >= s_sum;
      shl    = {rem_ff, quo_ff[DIV_W-1]};
      diff   = {1'b0, shl} - {2'b0, dvsr_ff};
      q_bit  = !diff[17];
      quo_next = {quo_ff[DIV_W-2:0], q_bit};
      num = pos_ff[cmd.axis] ? CELL_ONE - {1'b0, frac_ff[cmd.axis]}
                             : {1'b0, frac_ff[cmd.axis]};
      if (nb_ff[0] < nb_ff[1] && nb_ff[0] < nb_ff[2]) begin
         adv = 2'd0;
      end else if (nb_ff[1] < nb_ff[2]) begin
         adv = 2'd1;
      end else begin
         adv = 2'd2;
      end
      nb_sum = {1'b0, nb_ff[adv]} + {1'b0, inc_ff[adv]};
      neg = (face_ff == 2'd0) ? 1'b0 : pos_ff[2'(face_ff - 2'd1)];
   end

   always_comb begin
      cell_in  = cell_ff;
      nb_in    = nb_ff;
      inc_in   = inc_ff;
      dabs_in  = dabs_ff;
      frac_in  = frac_ff;
      pos_in   = pos_ff;
      dpos_in  = dpos_ff;
      trav_in  = trav_ff;
      limit_in = limit_ff;
      face_in  = face_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      sqrt_in  = sqrt_ff;
      sel_in   = sel_ff;
      ax_in    = ax_ff;
      mag_in   = mag_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (busy_ff) begin
         if (sqrt_ff) begin
            if (s_ge) begin
               srem_in = srem_ff - s_sum[31:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            busy_in = |bit_ff[31:2];
         end else begin
            quo_in = quo_next;
            rem_in = q_bit ? diff[LEN_W-1:0] : shl[LEN_W-1:0];
            cnt_in = cnt_ff - ITER_W'(1);
            if (cnt_ff == ITER_W'(1)) begin
               busy_in = 1'b0;
               case (sel_ff)
                  DIV_MAG: begin
                     mag_in = MAG_W'(quo_next);
                     pos_in[ax_ff] = dpos_ff[ax_ff] && (MAG_W'(quo_next) != '0);
                  end
                  DIV_INC: inc_in[ax_ff] = sat32(64'(quo_next));
                  default: nb_in[ax_ff] = sat32(64'(quo_next));
               endcase
            end
         end
      end

      if (cmd.load) begin
         busy_in  = 1'b1;
         sqrt_in  = 1'b1;
         srem_in  = sq_sum;
         root_in  = '0;
         bit_in   = 32'h4000_0000;
         trav_in  = '0;
         face_in  = 2'd0;
         limit_in = req_data.max_dist;
         for (int a = 0; a < 3; a++) begin
            cell_in[a] = CELL_BITS'(org[a] >>> FRAC_BITS);
            dabs_in[a] = 17'(dir[a][15] ? -dw[a] : dw[a]);
            dpos_in[a] = dir[a] > 16'sd0;
            frac_in[a] = org[a][FRAC_BITS-1:0];
         end
      end

      if (cmd.div_start) begin
         busy_in = 1'b1;
         sqrt_in = 1'b0;
         sel_in  = cmd.div_sel;
         ax_in   = cmd.axis;
         cnt_in  = ITER_W'(DIV_W);
         rem_in  = '0;
         case (cmd.div_sel)
            DIV_MAG: begin
               quo_in  = DIV_W'({dabs_ff[cmd.axis], {DIR_FRAC{1'b0}}});
               dvsr_in = root_ff[LEN_W-1:0];
            end
            DIV_INC: begin
               quo_in  = INC_NUM;
               dvsr_in = LEN_W'(mag_ff);
            end
            default: begin
               quo_in  = DIV_W'({num, {DIR_FRAC{1'b0}}});
               dvsr_in = LEN_W'(mag_ff);
            end
         endcase
      end

      if (cmd.sat_axis) begin
         inc_in[cmd.axis] = 32'hFFFF_FFFF;
         nb_in[cmd.axis]  = 32'hFFFF_FFFF;
         pos_in[cmd.axis] = 1'b0;
      end

      if (cmd.advance) begin
         trav_in     = nb_ff[adv];
         nb_in[adv]  = sat32(64'(nb_sum));
         cell_in[adv] = pos_ff[adv] ? cell_ff[adv] + CELL_BITS'(1)
                                    : cell_ff[adv] - CELL_BITS'(1);
         face_in     = adv + 2'd1;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.kind  = cmd.emit_kind;
         if (cmd.emit_kind == KIND_MISS) begin
            rsp_in.cell_x          = '0;
            rsp_in.cell_y          = '0;
            rsp_in.cell_z          = '0;
            rsp_in.distance        = '0;
            rsp_in.normal_axis     = 2'd0;
            rsp_in.normal_negative = 1'b0;
         end else begin
            rsp_in.cell_x          = 16'(cell_ff[0]);
            rsp_in.cell_y          = 16'(cell_ff[1]);
            rsp_in.cell_z          = 16'(cell_ff[2]);
            rsp_in.distance        = trav_ff[30:0];
            rsp_in.normal_axis     = face_ff;
            rsp_in.normal_negative = neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff  <= cell_in;
      nb_ff    <= nb_in;
      inc_ff   <= inc_in;
      dabs_ff  <= dabs_in;
      frac_ff  <= frac_in;
      pos_ff   <= pos_in;
      dpos_ff  <= dpos_in;
      trav_ff  <= trav_in;
      limit_ff <= limit_in;
      face_ff  <= face_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      cnt_ff   <= cnt_in;
      sqrt_ff  <= sqrt_in;
      sel_ff   <= sel_in;
      ax_ff    <= ax_in;
      mag_ff   <= mag_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.busy       = busy_ff;
   assign sts.len_zero   = root_ff[LEN_W-1:0] == '0;
   assign sts.mag_zero   = mag_ff == '0;
   assign sts.past_limit = trav_ff > {1'b0, limit_ff};
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_data       = rsp_ff;
   assign rsp_valid      = rsp_valid_ff;

endmodule

### rtl/vrt_ctrl.sv
module vrt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  vrt_pkg::req_type req_data,
   output logic             req_stall,
   input  vrt_pkg::sts_type sts,
   output vrt_pkg::cmd_type cmd
);
   import vrt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQRT = 3'd1;
   localparam logic [2:0] S_AXIS = 3'd2;
   localparam logic [2:0] S_MAGW = 3'd3;
   localparam logic [2:0] S_INCW = 3'd4;
   localparam logic [2:0] S_NBW  = 3'd5;
   localparam logic [2:0] S_STEP = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] kind_ff, kind_in;
   logic       active_ff, active_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      kind_in   = kind_ff;
      active_in = active_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      cmd.emit_kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_START) begin
                  cmd.load  = 1'b1;
                  active_in = 1'b1;
                  axis_in   = 2'd0;
                  state_in  = S_SQRT;
               end else if (active_ff) begin
                  if (req_data.cell_stops) begin
                     kind_in  = KIND_HIT;
                     state_in = S_EMIT;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_STEP;
                  end
               end
            end
         end
         S_SQRT: begin
            if (!sts.busy) begin
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            if (sts.len_zero) begin
               cmd.sat_axis = 1'b1;
               if (axis_ff == 2'd2) begin
                  kind_in  = KIND_QUERY;
                  state_in = S_EMIT;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_MAG;
               state_in      = S_MAGW;
            end
         end
         S_MAGW: begin
            if (!sts.busy) begin
               if (sts.mag_zero) begin
                  cmd.sat_axis = 1'b1;
                  if (axis_ff == 2'd2) begin
                     kind_in  = KIND_QUERY;
                     state_in = S_EMIT;
                  end else begin
                     axis_in  = axis_ff + 2'd1;
                     state_in = S_AXIS;
                  end
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_INC;
                  state_in      = S_INCW;
               end
            end
         end
         S_INCW: begin
            if (!sts.busy) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_NB;
               state_in      = S_NBW;
            end
         end
         S_NBW: begin
            if (!sts.busy) begin
               if (axis_ff == 2'd2) begin
                  kind_in  = KIND_QUERY;
                  state_in = S_EMIT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_AXIS;
               end
            end
         end
         S_STEP: begin
            kind_in  = sts.past_limit ? KIND_MISS : KIND_QUERY;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (kind_ff != KIND_QUERY) begin
                  active_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      kind_ff <= kind_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.busy)
      else $error("divide started while unit busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written over a pending transaction");
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> sts.busy)
      else $error("square root did not start after load");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_start, cmd.sat_axis, cmd.advance, cmd.emit}))
      else $error("conflicting datapath commands");

endmodule

### rtl/voxel_ray_traversal.sv
// Start transaction: the square root runs first, then per axis the S_AXIS state and up to
// three divides on the one shared divider, then the result is emitted.
// Reply transaction: advances one cell, then emits; a hit emits without advancing. One transaction in work at a time.
// The result sits in an output register, so the next request is taken while it waits.
// Synchronous active-high reset clears the controller, unit busy flag and output valid.
module voxel_ray_traversal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  vrt_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output vrt_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);
   import vrt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vrt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

### tb/voxel_ray_traversal_tb.sv
module voxel_ray_traversal_tb;
   import vrt_pkg::*;

   localparam int IDLE_PCT    = 28;
   localparam int STALL_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   voxel_ray_traversal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

   always #6 clock = ~clock;

   // traversal state
   logic [15:0] cur_cell [3];
   logic [31:0] boundary [3];
   logic [31:0] increment [3];
   logic        step_pos [3];
   logic [31:0] walked;
   logic [30:0] dist_cap;
   logic [1:0]  entry_face;
   logic        ray_live;

   rsp_type expected_rsp [$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   logic    calm = 1'b0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] clamp32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic rsp_type face_result(input logic [1:0] k);
      rsp_type r;
      r.kind = k;
      r.cell_x = cur_cell[0];
      r.cell_y = cur_cell[1];
      r.cell_z = cur_cell[2];
      r.distance = walked[30:0];
      r.normal_axis = entry_face;
      r.normal_negative = (entry_face != 0) ? step_pos[entry_face - 1] : 1'b0;
      return r;
   endfunction

   task automatic predict_traversal(input req_type t);
      logic signed [15:0] d [3];
      logic [31:0] o [3];
      logic [63:0] sq;
      logic [63:0] len;
      logic [63:0] mag;
      logic [63:0] ad;
      logic [63:0] frac;
      logic [63:0] num;
      int a;
      d[0] = t.dir_x; d[1] = t.dir_y; d[2] = t.dir_z;
      o[0] = t.origin_x; o[1] = t.origin_y; o[2] = t.origin_z;
      if (t.op == OP_START) begin
         sq = 0;
         for (a = 0; a < 3; a++) sq += 64'(longint'(d[a]) * longint'(d[a]));
         len = 64'(floor_sqrt(sq));
         for (a = 0; a < 3; a++) begin
            frac = 64'(o[a][FRAC_BITS-1:0]);
            mag = 0;
            step_pos[a] = 1'b0;
            if (len != 0) begin
               ad = (d[a] < 0) ? 64'(-longint'(d[a])) : 64'(d[a]);
               mag = (ad << DIR_FRAC) / len;
               step_pos[a] = (d[a] > 0) && (mag != 0);
            end
            cur_cell[a] = o[a][FRAC_BITS +: 16];
            if (mag == 0) begin
               increment[a] = 32'hFFFF_FFFF;
               boundary[a] = 32'hFFFF_FFFF;
            end else begin
               num = step_pos[a] ? ((64'd1 << FRAC_BITS) - frac) : frac;
               increment[a] = clamp32((64'd1 << (FRAC_BITS + DIR_FRAC)) / mag);
               boundary[a] = clamp32((num << DIR_FRAC) / mag);
            end
         end
         walked = 0;
         entry_face = 0;
         dist_cap = t.max_dist;
         ray_live = 1'b1;
         expected_rsp.push_back(face_result(KIND_QUERY));
      end else if (ray_live) begin
         if (t.cell_stops) begin
            ray_live = 1'b0;
            expected_rsp.push_back(face_result(KIND_HIT));
         end else begin
            if (boundary[0] < boundary[1] && boundary[0] < boundary[2]) a = 0;
            else if (boundary[1] < boundary[2]) a = 1;
            else a = 2;
            walked = boundary[a];
            boundary[a] = clamp32(64'(boundary[a]) + 64'(increment[a]));
            cur_cell[a] = cur_cell[a] + (step_pos[a] ? 16'd1 : 16'hFFFF);
            entry_face = 2'(a + 1);
            if (walked > 32'(dist_cap)) begin
               ray_live = 1'b0;
               expected_rsp.push_back('{kind: KIND_MISS, default: '0});
            end else begin
               expected_rsp.push_back(face_result(KIND_QUERY));
            end
         end
      end
   endtask

   task automatic send_item(input req_type t);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_traversal(t);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected result", 64'(rsp_data), 64'd0);
         end else begin
            rsp_type w;
            w = expected_rsp.pop_front();
            if (rsp_data.kind != w.kind) report("kind", 64'(rsp_data.kind), 64'(w.kind));
            if (rsp_data.cell_x != w.cell_x)
               report("cell_x", 64'(rsp_data.cell_x), 64'(w.cell_x));
            if (rsp_data.cell_y != w.cell_y)
               report("cell_y", 64'(rsp_data.cell_y), 64'(w.cell_y));
            if (rsp_data.cell_z != w.cell_z)
               report("cell_z", 64'(rsp_data.cell_z), 64'(w.cell_z));
            if (rsp_data.distance != w.distance)
               report("distance", 64'(rsp_data.distance), 64'(w.distance));
            if (rsp_data.normal_axis != w.normal_axis)
               report("normal_axis", 64'(rsp_data.normal_axis), 64'(w.normal_axis));
            if (rsp_data.normal_negative != w.normal_negative)
               report("normal_negative", 64'(rsp_data.normal_negative),
                      64'(w.normal_negative));
         end
      end
      rsp_stall <= (!calm && $urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("voxel_ray_traversal test failed");
         $finish;
      end
   end

   function automatic req_type ray_start(input logic [31:0] ox, input logic [31:0] oy,
                                         input logic [31:0] oz, input logic [15:0] dx,
                                         input logic [15:0] dy, input logic [15:0] dz,
                                         input logic [30:0] md);
      req_type t;
      t = '0;
      t.op = OP_START;
      t.origin_x = ox; t.origin_y = oy; t.origin_z = oz;
      t.dir_x = dx; t.dir_y = dy; t.dir_z = dz;
      t.max_dist = md;
      t.cell_stops = 1'($urandom_range(1));
      return t;
   endfunction

   function automatic req_type reply(input logic stops);
      req_type t;
      logic [223:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = noise[$bits(req_type)-1:0];
      t.op = OP_REPLY;
      t.cell_stops = stops;
      return t;
   endfunction

   task automatic test_directed;
      send_item(reply(1'b0));
      send_item(reply(1'b1));
      send_item(ray_start(32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000,
                          16'sd16384, 16'sd0, 16'sd0, 31'h0004_0000));
      repeat (5) send_item(reply(1'b0));
      send_item(ray_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h7FFF, 16'h8000, 16'h7FFF,
                          31'h7FFF_FFFF));
      send_item(reply(1'b0));
      send_item(reply(1'b1));
      send_item(ray_start(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0,
                          31'h0));
      send_item(reply(1'b0));
      send_item(ray_start(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0001, 16'h0001, 31'h0));
      send_item(reply(1'b1));
      send_item(ray_start(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 31'h0010_0000));
      send_item(ray_start(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hC000, 31'h0010_0000));
      repeat (4) send_item(reply(1'b0));
      send_item(reply(1'b1));
   endtask

   task automatic test_random_rays(input int budget);
      int sent;
      int n;
      req_type t;
      sent = 0;
      while (sent < budget) begin
         calm = (sent > budget / 2 && sent < budget / 2 + 150);
         t = ray_start($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       16'($urandom), 31'($urandom));
         if ($urandom_range(3) != 0) begin
            t.max_dist = 31'($urandom_range(31'h000C_0000));
            if ($urandom_range(1)) begin
               t.origin_x = $signed(t.origin_x) >>> $urandom_range(12);
               t.origin_y = $signed(t.origin_y) >>> $urandom_range(12);
            end
         end
         case ($urandom_range(7))
            0: t.dir_x = '0;
            1: begin t.dir_y = '0; t.dir_z = '0; end
            2: t.dir_x = $signed(t.dir_x) >>> 10;
            3: begin t.dir_x = t.dir_y; t.dir_z = t.dir_y; end
            default: ;
         endcase
         send_item(t);
         sent++;
         n = $urandom_range(12);
         repeat (n) begin
            send_item(reply($urandom_range(15) == 0));
            sent++;
         end
         if ($urandom_range(4) == 0) begin
            send_item(reply(1'b1));
            send_item(reply(1'($urandom_range(1))));
            sent += 2;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      int guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_rays(1250);
      req_valid <= 1'b0;
      guard = 0;
      while (expected_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("voxel_ray_traversal test passed");
      end else begin
         $display("voxel_ray_traversal test failed");
      end
      $finish;
   end

endmodule
